>>> hdl/dotq_pkg.sv
// Package for the deadline ordered timer queue.
// Holds sizes, word types, codes and the controller/datapath interface structs.
// No dependencies.
package dotq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TIME_WIDTH  = 32;
   localparam int ID_WIDTH    = 8;
   localparam int DELAY_WIDTH = 31;
   localparam int CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_WIDTH   = $clog2(QUEUE_DEPTH);

   // request codes
   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_ADD  = 1'b1;

   // result codes
   localparam logic [1:0] KIND_EXPIRED  = 2'd0;
   localparam logic [1:0] KIND_ACCEPTED = 2'd1;
   localparam logic [1:0] KIND_REJECTED = 2'd2;

   typedef struct packed {
      logic                   req_type;
      logic [ID_WIDTH-1:0]    task_id;
      logic [DELAY_WIDTH-1:0] delay_ticks;
   } req_word_type;

   typedef struct packed {
      logic [1:0]          result_kind;
      logic [ID_WIDTH-1:0] result_task;
      logic                last;
      logic                pending;
   } rsp_word_type;

   // controller -> datapath
   typedef struct packed {
      logic take;    // capture request word, tick advances time
      logic insert;  // insert captured task, emit accepted
      logic reject;  // emit rejected
      logic pop;     // drop head entry, emit expired
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;      // queue holds QUEUE_DEPTH entries
      logic head_due;  // head entry is due
      logic next_due;  // entry behind the head is due too
      logic out_free;  // output register can take a word this cycle
   } status_type;

endpackage

>>> hdl/deadline_ordered_timer_queue.sv
// Top level of the deadline ordered timer queue.
// Instantiates dotq_ctrl and dotq_datapath; depends on dotq_pkg.
//
//   channel  direction  handshake              word
//   req      in         req_valid/req_ready    dotq_pkg::req_word_type
//   rsp      out        rsp_valid/rsp_ready    dotq_pkg::rsp_word_type
//
// An add forms the deadline as the request is taken, then does the parallel
// insert into the sorted entry row. A tick advances time as it is taken,
// then drains expired tasks from the head of the row one at a time, and
// ends when it finds the head not due.
// One request is in work at a time; req_ready is high only when idle.
// A full output register stalls the insert or drain until rsp_ready.
// Synchronous reset clears time, entry count and the output valid.
module deadline_ordered_timer_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  dotq_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output dotq_pkg::rsp_word_type rsp_word
);

   dotq_pkg::cmd_type    cmd;
   dotq_pkg::status_type status;

   dotq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_word.req_type),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dotq_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

>>> hdl/dotq_ctrl.sv
// Controller for the deadline ordered timer queue.
// Sequences add and tick requests; depends on dotq_pkg.
module dotq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_type,
   output logic                req_ready,
   input  dotq_pkg::status_type status,
   output dotq_pkg::cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ADD   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd.take   = accept;
      cmd.insert = 1'b0;
      cmd.reject = 1'b0;
      cmd.pop    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_type == dotq_pkg::REQ_ADD) ? ST_ADD : ST_DRAIN;
            end
         end
         ST_ADD: begin
            if (status.out_free) begin
               cmd.insert = !status.full;
               cmd.reject = status.full;
               state_in   = ST_IDLE;
            end
         end
         ST_DRAIN: begin
            // one due task per cycle from the head, while the output register is free
            if (!status.head_due) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.pop = 1'b1;
               if (!status.next_due) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/dotq_datapath.sv
// Datapath for the deadline ordered timer queue: time counter, sorted entry
// row with parallel insert and head pop, output register. Depends on dotq_pkg.
module dotq_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  dotq_pkg::req_word_type req_word,
   input  dotq_pkg::cmd_type      cmd,
   output dotq_pkg::status_type   status,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output dotq_pkg::rsp_word_type rsp_word
);

   localparam int DEPTH = dotq_pkg::QUEUE_DEPTH;
   localparam int TW    = dotq_pkg::TIME_WIDTH;
   localparam int IW    = dotq_pkg::ID_WIDTH;
   localparam int CW    = dotq_pkg::CNT_WIDTH;

   logic [TW-1:0] dl_ff [DEPTH];
   logic [IW-1:0] id_ff [DEPTH];
   logic [CW-1:0] count_ff;
   logic [TW-1:0] time_ff;
   logic [TW-1:0] new_dl_ff;
   logic [IW-1:0] new_id_ff;
   logic          rsp_valid_ff;
   dotq_pkg::rsp_word_type rsp_word_ff;

   logic [DEPTH-1:0] before_new;  // live entry strictly earlier than new deadline
   logic [TW-1:0]    diff_head;
   logic [TW-1:0]    diff_next;
   logic [TW-1:0]    diff_new [DEPTH];

   // wrap-safe compares against the new deadline
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         diff_new[i]   = dl_ff[i] - new_dl_ff;
         before_new[i] = (CW'(i) < count_ff) && diff_new[i][TW-1];
      end
   end

   // due test on the two front entries
   assign diff_head = dl_ff[0] - time_ff;
   assign diff_next = dl_ff[1] - time_ff;

   assign status.full     = (count_ff == CW'(DEPTH));
   assign status.head_due = (count_ff != '0) &&
                            ((diff_head == '0) || diff_head[TW-1]);
   assign status.next_due = (count_ff > CW'(1)) &&
                            ((diff_next == '0) || diff_next[TW-1]);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // time, captured request, count
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (cmd.take && (req_word.req_type == dotq_pkg::REQ_TICK)) begin
            time_ff <= time_ff + TW'(1);
         end
         if (cmd.insert) begin
            count_ff <= count_ff + CW'(1);
         end else if (cmd.pop) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         new_dl_ff <= time_ff + TW'(req_word.delay_ticks);
         new_id_ff <= req_word.task_id;
      end
   end

   // entry row: sorted list is a prefix of earlier entries, so each slot
   // decides locally whether to keep, take the new task, or shift up; a pop shifts all down
   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         if (cmd.insert) begin
            if (!before_new[i]) begin
               if (i == 0) begin
                  dl_ff[i] <= new_dl_ff;
                  id_ff[i] <= new_id_ff;
               end else if (before_new[i-1]) begin
                  dl_ff[i] <= new_dl_ff;
                  id_ff[i] <= new_id_ff;
               end else begin
                  dl_ff[i] <= dl_ff[i-1];
                  id_ff[i] <= id_ff[i-1];
               end
            end
         end else if (cmd.pop) begin
            if (i < DEPTH - 1) begin
               dl_ff[i] <= dl_ff[i+1];
               id_ff[i] <= id_ff[i+1];
            end
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.insert || cmd.reject || cmd.pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         rsp_word_ff.result_kind <= dotq_pkg::KIND_ACCEPTED;
         rsp_word_ff.result_task <= new_id_ff;
         rsp_word_ff.last        <= 1'b1;
         rsp_word_ff.pending     <= 1'b1;
      end else if (cmd.reject) begin
         rsp_word_ff.result_kind <= dotq_pkg::KIND_REJECTED;
         rsp_word_ff.result_task <= new_id_ff;
         rsp_word_ff.last        <= 1'b1;
         rsp_word_ff.pending     <= 1'b1;
      end else if (cmd.pop) begin
         rsp_word_ff.result_kind <= dotq_pkg::KIND_EXPIRED;
         rsp_word_ff.result_task <= id_ff[0];
         rsp_word_ff.last        <= !status.next_due;
         rsp_word_ff.pending     <= (count_ff > CW'(1));
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

>>> tb/deadline_ordered_timer_queue_tb.sv
// Self-checking testbench for deadline_ordered_timer_queue: a directed table,
// then random words, checked against a sorted-queue predictor, with random stalls.
// Depends on dotq_pkg and the deadline_ordered_timer_queue RTL.
module deadline_ordered_timer_queue_tb;

   localparam int QD            = dotq_pkg::QUEUE_DEPTH;
   localparam int TW            = dotq_pkg::TIME_WIDTH;
   localparam int IW            = dotq_pkg::ID_WIDTH;
   localparam int DW            = dotq_pkg::DELAY_WIDTH;
   localparam int RESET_CYCLES  = 12;
   localparam int RANDOM_WORDS  = 136;
   localparam int BURST_EVERY   = 40;
   localparam int BURST_ADDS    = QD + 2;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 40;
   localparam int WATCHDOG_TIME = 10_000_000;

   // one row of the directed plan
   typedef struct {
      dotq_pkg::req_word_type word;
      bit                     typed;
      dotq_pkg::rsp_word_type want;
   } plan_row_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   dotq_pkg::req_word_type req_word  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   dotq_pkg::rsp_word_type rsp_word;

   // predictor state
   logic [TW-1:0] now_tick;
   logic [TW-1:0] due_at [QD];
   logic [IW-1:0] slot_id [QD];
   int            slot_count;

   dotq_pkg::rsp_word_type step_rsp[$];
   dotq_pkg::rsp_word_type awaited_rsp[$];
   plan_row_type           plan[$];

   int  mismatch_count = 0;
   int  words_sent     = 0;
   int  results_seen   = 0;
   int  expired_seen   = 0;
   int  accepted_seen  = 0;
   int  rejected_seen  = 0;
   int  widest_expiry  = 0;
   bit  hold_now       = 1'b0;

   deadline_ordered_timer_queue DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always #5 clock = ~clock;

   // watchdog
   initial begin
      #(WATCHDOG_TIME);
      $display("deadline_ordered_timer_queue_tb: errors");
      $finish;
   end

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // wrap-safe: a strictly earlier than b
   function automatic bit earlier(input logic [TW-1:0] a,
                                  input logic [TW-1:0] b);
      logic [TW-1:0] d;
      d = a - b;
      return d[TW-1];
   endfunction

   function automatic dotq_pkg::rsp_word_type make_rsp(input logic [1:0] kind,
                                                       input logic [IW-1:0] id,
                                                       input logic last_bit,
                                                       input logic pend_bit);
      dotq_pkg::rsp_word_type r;
      r.result_kind = kind;
      r.result_task = id;
      r.last        = last_bit;
      r.pending     = pend_bit;
      return r;
   endfunction

   function automatic dotq_pkg::req_word_type add_word(input logic [IW-1:0] id,
                                                       input logic [DW-1:0] delay);
      dotq_pkg::req_word_type w;
      w.req_type    = dotq_pkg::REQ_ADD;
      w.task_id     = id;
      w.delay_ticks = delay;
      return w;
   endfunction

   function automatic dotq_pkg::req_word_type tick_word(input logic [IW-1:0] id,
                                                        input logic [DW-1:0] delay);
      dotq_pkg::req_word_type w;
      w.req_type    = dotq_pkg::REQ_TICK;
      w.task_id     = id;
      w.delay_ticks = delay;
      return w;
   endfunction

   function automatic void plan_row(input dotq_pkg::req_word_type w, input bit typed,
                                    input dotq_pkg::rsp_word_type want);
      plan_row_type row;
      row.word  = w;
      row.typed = typed;
      row.want  = want;
      plan.push_back(row);
   endfunction

   // sorted timer queue: one request word in, its result words into step_rsp
   function automatic void advance_timer_queue(input dotq_pkg::req_word_type w);
      logic [TW-1:0] dl;
      int pos;
      int n;
      step_rsp.delete();
      if (w.req_type == dotq_pkg::REQ_ADD) begin
         if (slot_count >= QD) begin
            step_rsp.push_back(make_rsp(dotq_pkg::KIND_REJECTED, w.task_id, 1'b1, 1'b1));
         end else begin
            dl  = now_tick + {1'b0, w.delay_ticks};
            pos = 0;
            while (pos < slot_count && earlier(due_at[pos], dl)) pos++;
            for (int i = slot_count; i > pos; i--) begin
               due_at[i]  = due_at[i-1];
               slot_id[i] = slot_id[i-1];
            end
            due_at[pos]  = dl;
            slot_id[pos] = w.task_id;
            slot_count++;
            step_rsp.push_back(make_rsp(dotq_pkg::KIND_ACCEPTED, w.task_id, 1'b1, 1'b1));
         end
      end else begin
         now_tick = now_tick + 1'b1;
         n = 0;
         while (n < slot_count && (due_at[n] == now_tick || earlier(due_at[n], now_tick)))
            n++;
         for (int i = 0; i < n; i++)
            step_rsp.push_back(make_rsp(dotq_pkg::KIND_EXPIRED, slot_id[i], i + 1 == n,
                                        slot_count - i - 1 > 0));
         for (int i = n; i < slot_count; i++) begin
            due_at[i-n]  = due_at[i];
            slot_id[i-n] = slot_id[i];
         end
         slot_count = slot_count - n;
         if (n > widest_expiry) widest_expiry = n;
      end
   endfunction

   // mostly short gaps, some zero, a few long
   function automatic int pick_gap(input bit allow_zero);
      int r;
      r = $urandom_range(0, 99);
      if (allow_zero && r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [DW-1:0] pick_delay();
      int r;
      r = $urandom_range(0, 99);
      if (r < 88) return DW'($urandom_range(0, 12));
      if (r < 95) return DW'($urandom_range(13, 60));
      return DW'($urandom);
   endfunction

   // offer one word, hold it until taken, then queue its expected results
   task automatic offer_word(input dotq_pkg::req_word_type w, input bit typed,
                             input dotq_pkg::rsp_word_type want, input bit more);
      int gap;
      req_word  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      advance_timer_queue(w);
      if (typed) awaited_rsp.push_back(want);
      else foreach (step_rsp[i]) awaited_rsp.push_back(step_rsp[i]);
      words_sent++;
      gap = pick_gap(1'b1);
      if (gap > 0 || !more) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // receiver: random stalls, plus one long hold-off when asked
   initial begin : rsp_side
      bit  hold_done;
      bit  level;
      int  span;
      hold_done = 1'b0;
      forever begin
         if (hold_now && !hold_done) begin
            hold_done = 1'b1;
            level     = 1'b0;
            span      = HOLD_CYCLES;
         end else if ($urandom_range(0, 3) == 0) begin
            level = 1'b0;
            span  = pick_gap(1'b0);
         end else begin
            level = 1'b1;
            span  = $urandom_range(1, 16);
         end
         rsp_ready <= level;
         repeat (span) @(posedge clock);
      end
   end

   // result checker
   always @(posedge clock) begin
      dotq_pkg::rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         case (rsp_word.result_kind)
            dotq_pkg::KIND_EXPIRED:  expired_seen++;
            dotq_pkg::KIND_ACCEPTED: accepted_seen++;
            dotq_pkg::KIND_REJECTED: rejected_seen++;
            default: ;
         endcase
         if (awaited_rsp.size() == 0) begin
            flag_mismatch($sformatf("unexpected result word %h", rsp_word));
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_word.result_kind !== want.result_kind)
               flag_mismatch($sformatf("result_kind %0d, want %0d",
                                       rsp_word.result_kind, want.result_kind));
            if (rsp_word.result_task !== want.result_task)
               flag_mismatch($sformatf("result_task %h, want %h",
                                       rsp_word.result_task, want.result_task));
            if (rsp_word.last !== want.last)
               flag_mismatch($sformatf("last %b, want %b", rsp_word.last, want.last));
            if (rsp_word.pending !== want.pending)
               flag_mismatch($sformatf("pending %b, want %b",
                                       rsp_word.pending, want.pending));
         end
      end
   end

   // stimulus
   initial begin : req_side
      dotq_pkg::rsp_word_type none;
      dotq_pkg::req_word_type w;
      int                     sent;
      none       = '0;
      now_tick   = '0;
      slot_count = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed plan
      plan_row(tick_word(8'h00, '0), 1'b0, none);                  // tick on empty queue
      plan_row(add_word(8'h00, '0), 1'b1,
               make_rsp(dotq_pkg::KIND_ACCEPTED, 8'h00, 1'b1, 1'b1));
      plan_row(tick_word(8'hFF, '1), 1'b1,
               make_rsp(dotq_pkg::KIND_EXPIRED, 8'h00, 1'b1, 1'b0));
      plan_row(add_word(8'h55, 31'd2), 1'b0, none);
      plan_row(add_word(8'hAA, 31'd2), 1'b0, none);                // equal deadline
      plan_row(add_word(8'h11, 31'd1), 1'b0, none);
      for (int i = 0; i < QD - 3; i++)
         plan_row(add_word(IW'(8'h20 + i), 31'd2), 1'b0, none);   // fill to the brim
      plan_row(add_word(8'h77, 31'd5), 1'b1,
               make_rsp(dotq_pkg::KIND_REJECTED, 8'h77, 1'b1, 1'b1));
      plan_row(tick_word(8'h00, '0), 1'b1,
               make_rsp(dotq_pkg::KIND_EXPIRED, 8'h11, 1'b1, 1'b1));
      plan_row(tick_word(8'h00, '0), 1'b0, none);                  // wide expiry
      plan_row(add_word(8'hFF, '1), 1'b1,
               make_rsp(dotq_pkg::KIND_ACCEPTED, 8'hFF, 1'b1, 1'b1));
      plan_row(tick_word(8'h5A, 31'h2AAAAAAA), 1'b0, none);        // nothing due
      foreach (plan[i]) offer_word(plan[i].word, plan[i].typed, plan[i].want, 1'b1);

      // random words, with periodic add bursts that overfill the queue
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         if (sent % BURST_EVERY == 0) begin
            hold_now = 1'b1;
            for (int i = 0; i < BURST_ADDS; i++) begin
               w = add_word(IW'($urandom_range(0, 255)), DW'($urandom_range(0, 4)));
               offer_word(w, 1'b0, none, 1'b1);
            end
            sent += BURST_ADDS;
         end else begin
            if ($urandom_range(0, 99) < 55)
               w = add_word(IW'($urandom_range(0, 255)), pick_delay());
            else
               w = tick_word(IW'($urandom_range(0, 255)), DW'($urandom));
            sent++;
            offer_word(w, 1'b0, none, sent < RANDOM_WORDS);
         end
      end
      req_valid <= 1'b0;

      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d request words and %0d result words", words_sent, results_seen);
      $display("  %0d expired, %0d accepted, %0d rejected; widest expiry %0d tasks",
               expired_seen, accepted_seen, rejected_seen, widest_expiry);
      if (mismatch_count == 0) begin
         $display("deadline_ordered_timer_queue_tb: clean");
      end else begin
         $display("deadline_ordered_timer_queue_tb: errors");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/dotq_pkg.sv
hdl/dotq_ctrl.sv
hdl/dotq_datapath.sv
hdl/deadline_ordered_timer_queue.sv
tb/deadline_ordered_timer_queue_tb.sv
